// ===== hdl/gne_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gne_pkg: shared types and tables of the grid neighborhood enumerator
// Job record, offset type, row half-width table and status groups.
// ============================================================================
package gne_pkg;

    localparam int CoordW = 16;
    localparam int DataW  = 32;
    localparam int AddrW  = 3;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_CIRCLE_MODE = 1'b1;

    localparam logic [2:0] WINDOW_SIZE_RST = 3'd3;

    typedef logic signed [2:0] offs_t;

    typedef struct packed {
        logic [CoordW-1:0] cx;
        logic [CoordW-1:0] cy;
        logic [1:0]        r;
        logic              circ;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic idle;
        logic pend_valid;
    } back_stat_t;

    // floor(sqrt(r*r - dy*dy)) in circle mode, r in square mode
    function automatic logic [1:0] half_width(input logic [1:0] r, input offs_t dy,
                                              input logic circ);
        logic [2:0] mag;
        logic [1:0] a;
        logic [1:0] h;
        mag = dy[2] ? 3'(-dy) : 3'(dy);
        a   = mag[1:0];
        h   = 2'd0;
        if (!circ) begin
            h = r;
        end
        else begin
            unique case ({r, a})
                4'b11_00: h = 2'd3;
                4'b11_01: h = 2'd2;
                4'b11_10: h = 2'd2;
                4'b10_00: h = 2'd2;
                4'b10_01: h = 2'd1;
                4'b01_00: h = 2'd1;
                default:  h = 2'd0;
            endcase
        end
        return h;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/gne_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gne_front: configuration registers and center intake
// Holds window_size and circle_mode, turns each accepted center into a job.
// ============================================================================
module gne_front
    import gne_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [AddrW-1:0]  paddr,
    input  wire logic [DataW-1:0]  pwdata,
    output logic      [DataW-1:0]  prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CoordW-1:0] center_x,
    input  wire logic [CoordW-1:0] center_y,
    input  wire fifo_stat_t        fifo_stat,
    output logic                   push,
    output job_t                   push_job
);

    logic [2:0] window_size_reg;
    logic       circle_mode_reg;
    logic       wr_en;
    logic [2:0] size_m1;
    logic [1:0] radius;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RST;
            circle_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_WINDOW_SIZE: window_size_reg <= pwdata[2:0];
                REG_CIRCLE_MODE: circle_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW_SIZE: prdata = {{(DataW-3){1'b0}}, window_size_reg};
            REG_CIRCLE_MODE: prdata = {{(DataW-1){1'b0}}, circle_mode_reg};
            default:         prdata = '0;
        endcase
    end

    // radius = (size - 1) / 2, zero for size zero
    assign size_m1 = window_size_reg - 3'd1;
    assign radius  = (window_size_reg == 3'd0) ? 2'd0 : size_m1[2:1];

    assign in_ready      = !fifo_stat.full;
    assign push          = in_valid & in_ready;
    assign push_job.cx   = center_x;
    assign push_job.cy   = center_y;
    assign push_job.r    = radius;
    assign push_job.circ = circle_mode_reg;

endmodule
`default_nettype wire

// ===== hdl/gne_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gne_fifo: two-entry job queue
// Decouples center intake from neighbor generation.
// ============================================================================
module gne_fifo
    import gne_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      pop_job,
    output fifo_stat_t stat
);

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign pop_job    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/gne_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gne_back: neighbor generator
// Walks the window row by row, drops clipped cells and the center, and holds
// one cell back so the final one can carry last.
// ============================================================================
module gne_back
    import gne_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fifo_stat_t        fifo_stat,
    input  wire job_t              pop_job,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [CoordW-1:0] cell_x,
    output logic      [CoordW-1:0] cell_y,
    output logic                   last,
    output back_stat_t             stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    state_t            state_reg;
    job_t              job_reg;
    offs_t             dx_reg;
    offs_t             dy_reg;
    logic              pend_valid_reg;
    logic [CoordW-1:0] pend_x_reg;
    logic [CoordW-1:0] pend_y_reg;
    logic              out_valid_reg;
    logic [CoordW-1:0] out_x_reg;
    logic [CoordW-1:0] out_y_reg;
    logic              out_last_reg;

    logic [1:0]        half_cur;
    logic [1:0]        half_nxt;
    logic [1:0]        half_first;
    offs_t             dy_nxt;
    offs_t             pop_r_neg;
    logic [CoordW+1:0] x_sum;
    logic [CoordW+1:0] y_sum;
    logic              cand_ok;
    logic              row_end;
    logic              last_iter;
    logic              out_free;
    logic              stall;

    assign pop_r_neg  = -offs_t'({1'b0, pop_job.r});
    assign half_first = half_width(pop_job.r, pop_r_neg, pop_job.circ);
    assign half_cur   = half_width(job_reg.r, dy_reg, job_reg.circ);
    assign dy_nxt     = dy_reg + offs_t'(1);
    assign half_nxt   = half_width(job_reg.r, dy_nxt, job_reg.circ);

    assign x_sum = {2'b00, job_reg.cx} + {{(CoordW-1){dx_reg[2]}}, dx_reg};
    assign y_sum = {2'b00, job_reg.cy} + {{(CoordW-1){dy_reg[2]}}, dy_reg};

    assign cand_ok   = (x_sum[CoordW+1:CoordW] == 2'b00)
                     && (y_sum[CoordW+1:CoordW] == 2'b00)
                     && !((dx_reg == offs_t'(0)) && (dy_reg == offs_t'(0)));
    assign row_end   = (dx_reg == offs_t'({1'b0, half_cur}));
    assign last_iter = row_end && (dy_reg == offs_t'({1'b0, job_reg.r}));
    assign out_free  = !out_valid_reg || out_ready;
    assign stall     = cand_ok && pend_valid_reg && !out_free;
    assign pop       = (state_reg == ST_IDLE) && !fifo_stat.empty;

    assign out_valid       = out_valid_reg;
    assign cell_x          = out_x_reg;
    assign cell_y          = out_y_reg;
    assign last            = out_last_reg;
    assign stat.idle       = (state_reg == ST_IDLE);
    assign stat.pend_valid = pend_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            job_reg        <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            pend_valid_reg <= 1'b0;
            pend_x_reg     <= '0;
            pend_y_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        job_reg   <= pop_job;
                        dy_reg    <= pop_r_neg;
                        dx_reg    <= -offs_t'({1'b0, half_first});
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (!stall)
                    begin
                        if (cand_ok)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_x_reg     <= pend_x_reg;
                                out_y_reg     <= pend_y_reg;
                                out_last_reg  <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_x_reg     <= x_sum[CoordW-1:0];
                            pend_y_reg     <= y_sum[CoordW-1:0];
                        end
                        if (last_iter)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                        else if (row_end)
                        begin
                            dy_reg <= dy_nxt;
                            dx_reg <= -offs_t'({1'b0, half_nxt});
                        end
                        else
                        begin
                            dx_reg <= dx_reg + offs_t'(1);
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_x_reg      <= pend_x_reg;
                        out_y_reg      <= pend_y_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/grid_neighborhood_enumerator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// grid_neighborhood_enumerator_top: moving-window neighbor cell enumerator
// For each center (center_x, center_y) emits every in-grid neighbor of the
// square or circular window in row-major order, center excluded, with last
// on the final cell. A center is loaded from the queue, then the generator
// walks each window position (row widths summed, up to 49 for a 7x7 square)
// and closes by issuing the held cell, if any; output stalls hold the walk.
// A two-entry job queue takes new centers while the generator is busy.
// ============================================================================
module grid_neighborhood_enumerator_top
    import gne_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [AddrW-1:0]  paddr,
    input  wire logic [DataW-1:0]  pwdata,
    output logic      [DataW-1:0]  prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CoordW-1:0] center_x,
    input  wire logic [CoordW-1:0] center_y,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [CoordW-1:0] cell_x,
    output logic      [CoordW-1:0] cell_y,
    output logic                   last
);

    fifo_stat_t fifo_stat;
    back_stat_t back_stat;
    job_t       push_job;
    job_t       pop_job;
    logic       push;
    logic       pop;

    gne_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .center_x  (center_x),
        .center_y  (center_y),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_job  (push_job)
    );

    gne_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (fifo_stat)
    );

    gne_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .pop_job   (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .last      (last),
        .stat      (back_stat)
    );

    a_fifo_count: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("job queue both full and empty");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.idle |-> !back_stat.pend_valid)
        else $error("held cell left behind when generator went idle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!fifo_stat.empty && back_stat.idle))
        else $error("job taken from empty queue or by busy generator");

    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid) && last) |-> back_stat.idle)
        else $error("last cell issued while generator still walking");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench of the grid neighborhood enumerator
// Drives centers through the valid/ready input and programs the window over
// the APB port. A scoreboard enumerates the expected neighbor cells of each
// accepted center and checks every output beat in order. A directed pass
// covers grid corners, edges and each window setting. Random centers
// follow under three idling profiles, with one long output stall.
// ============================================================================
module tb_top;
    import gne_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 160;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_WINDOW    = 7;
    localparam int GRID_TOP      = 65535;
    localparam int REPORT_LIMIT  = 10;
    localparam int BATCH_ITEMS   = 8;
    localparam logic [AddrW-1:0] ADDR_WINDOW_SIZE = {REG_WINDOW_SIZE, 2'b00};
    localparam logic [AddrW-1:0] ADDR_CIRCLE_MODE = {REG_CIRCLE_MODE, 2'b00};

    typedef struct {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic              last;
    } cell_t;

    class neighbor_scoreboard;
        logic [2:0] window_size;
        logic       circle_mode;
        cell_t      pending_cells[$];
        int         mismatches;

        function new();
            window_size = WINDOW_SIZE_RST;
            circle_mode = 1'b0;
            mismatches  = 0;
        endfunction

        function int floor_sqrt(int v);
            int s;
            s = 0;
            while ((s + 1) * (s + 1) <= v)
                s++;
            return s;
        endfunction

        function void add_center(logic [CoordW-1:0] cx, logic [CoordW-1:0] cy);
            int    size;
            int    r;
            int    half;
            int    x;
            int    y;
            int    n;
            cell_t c;
            n    = 0;
            size = (int'(window_size) > MAX_WINDOW) ? MAX_WINDOW : int'(window_size);
            r    = (size >= 1) ? (size - 1) / 2 : 0;
            for (int dy = -r; dy <= r; dy++)
            begin
                y = int'(cy) + dy;
                if (y < 0 || y > GRID_TOP)
                    continue;
                half = circle_mode ? floor_sqrt(r * r - dy * dy) : r;
                for (int dx = -half; dx <= half; dx++)
                begin
                    x = int'(cx) + dx;
                    if (x < 0 || x > GRID_TOP)
                        continue;
                    if (dx == 0 && dy == 0)
                        continue;
                    c.x    = x[CoordW-1:0];
                    c.y    = y[CoordW-1:0];
                    c.last = 1'b0;
                    pending_cells.push_back(c);
                    n++;
                end
            end
            if (n > 0)
                pending_cells[pending_cells.size() - 1].last = 1'b1;
        endfunction

        function void check_cell(logic [CoordW-1:0] x, logic [CoordW-1:0] y, logic l);
            cell_t e;
            if (pending_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected cell: x=%0d y=%0d last=%0b", x, y, l);
            end
            else
            begin
                e = pending_cells.pop_front();
                if (e.x !== x || e.y !== y || e.last !== l)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: exp x=%0d y=%0d last=%0b got x=%0d y=%0d last=%0b",
                                 e.x, e.y, e.last, x, y, l);
                end
            end
        endfunction

        function int pending();
            return pending_cells.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [AddrW-1:0]  paddr;
    logic [DataW-1:0]  pwdata;
    logic [DataW-1:0]  prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic              out_valid;
    logic              out_ready;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic              last;

    neighbor_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_reqs;
    int cycle_count;

    grid_neighborhood_enumerator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .center_x  (center_x),
        .center_y  (center_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_cell(cell_x, cell_y, last);
    end

    // output side: random stalls, plus a long hold on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(input logic [2:0] size, input logic circ);
        write_reg(ADDR_WINDOW_SIZE, DataW'(size));
        write_reg(ADDR_CIRCLE_MODE, DataW'(circ));
        sb.window_size = size;
        sb.circle_mode = circ;
    endtask

    task automatic send_center(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        center_x <= x;
        center_y <= y;
        do @(posedge clk); while (!in_ready);
        sb.add_center(x, y);
    endtask

    // drop valid, wait for every expected cell, then let queued jobs finish
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CoordW-1:0] pick_coord();
        case ($urandom_range(3))
            0:       return CoordW'($urandom_range(3));
            1:       return CoordW'(GRID_TOP - $urandom_range(3));
            2:       return CoordW'($urandom_range(7)) << $urandom_range(13);
            default: return CoordW'($urandom);
        endcase
    endfunction

    initial
    begin
        sb            = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs     = 0;
        cycle_count   = 0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        center_x      = '0;
        center_y      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset window: 3x3 square
        send_center(16'd0, 16'd0);
        send_center(16'd65535, 16'd65535);
        send_center(16'd1000, 16'd2000);
        drain();

        set_window(3'd7, 1'b1);
        send_center(16'd0, 16'd0);
        send_center(16'd2, 16'd65533);
        send_center(16'd65535, 16'd0);
        send_center(16'd3, 16'd3);
        send_center(16'd65534, 16'd1);
        drain();

        set_window(3'd7, 1'b0);
        send_center(16'd0, 16'd65535);
        send_center(16'd65535, 16'd65535);
        send_center(16'd1, 16'd2);
        send_center(16'd40000, 16'd12345);
        drain();

        set_window(3'd0, 1'b0);
        send_center(16'd5, 16'd5);
        send_center(16'd0, 16'd0);
        drain();

        set_window(3'd1, 1'b1);
        send_center(16'd100, 16'd100);
        drain();

        set_window(3'd2, 1'b0);
        send_center(16'd0, 16'd1);
        send_center(16'd65535, 16'd3);
        drain();

        set_window(3'd6, 1'b1);
        send_center(16'd2, 16'd2);
        send_center(16'd65533, 16'd65535);
        drain();

        set_window(3'd4, 1'b1);
        send_center(16'd1, 16'd0);
        send_center(16'd30000, 16'd65534);
        drain();

        set_window(3'd5, 1'b1);
        send_center(16'd2, 16'd2);
        drain();

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 87 : 0;
            recv_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 16 : 0;
            for (int batch = 0; batch < 4; batch++)
            begin
                set_window(3'($urandom_range(7)), 1'($urandom_range(1)));
                if (mode == 2 && batch == 1)
                begin
                    set_window(3'd7, 1'b0);
                    hold_reqs++;
                end
                for (int i = 0; i < BATCH_ITEMS; i++)
                    send_center(pick_coord(), pick_coord());
                drain();
            end
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== grid_neighborhood_enumerator_top.f =====
hdl/gne_pkg.sv
hdl/gne_front.sv
hdl/gne_fifo.sv
hdl/gne_back.sv
hdl/grid_neighborhood_enumerator_top.sv
sim/tb_top.sv
